FILE: src/ifsp_pkg.sv
package ifsp_pkg;

  // Block sizing
  localparam int unsigned CHANNELS   = 6;
  localparam int unsigned COUNT_BITS = 16;
  localparam int unsigned FRAME_LEN  = CHANNELS + 2;
  localparam int unsigned POS_DONE   = CHANNELS + 2;
  localparam int unsigned POS_BITS   = $clog2(POS_DONE + 1);
  localparam int unsigned FB_IDX_W   = $clog2(FRAME_LEN);

  // Register widths
  localparam int unsigned ADDR_W = 7;
  localparam int unsigned BASE_W = 16;
  localparam int unsigned STEP_W = 8;
  localparam int unsigned CFG_W  = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_BASE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_STEP     = 2'd2;

  // Register reset values
  localparam logic [ADDR_W-1:0] ADDR_RESET = 7'd16;
  localparam logic [BASE_W-1:0] BASE_RESET = 16'd1000;
  localparam logic [STEP_W-1:0] STEP_RESET = 8'd10;
  localparam int unsigned       MID_PERCENT = 50;
  // Widths after reset: reset base plus fifty reset steps
  localparam logic [COUNT_BITS-1:0] WIDTH_RESET =
    COUNT_BITS'(int'(BASE_RESET) + MID_PERCENT * int'(STEP_RESET));

  // Reply codes
  localparam logic [7:0] REPLY_ACK = 8'h41;
  localparam logic [7:0] REPLY_NAK = 8'h4E;
  localparam logic [7:0] MODE_RADIO_OFF = 8'h01;

  // Stream layout
  localparam int unsigned OUT_BITS    = CHANNELS + 8 + 2 + 1 + 1;
  localparam int unsigned OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [1:0] {
    REQ_ADDR_WR = 2'd0,
    REQ_ADDR_RD = 2'd1,
    REQ_DATA    = 2'd2,
    REQ_TICK    = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_NONE      = 2'd0,
    ST_ACCEPTED  = 2'd1,
    ST_CSUM_FAIL = 2'd2
  } status_e;

  // Width bank load request
  typedef struct packed {
    logic                        load;
    logic [CHANNELS-1:0][7:0]    percent;
  } load_t;

endpackage

FILE: src/ifsp_width_bank.sv
module ifsp_width_bank
  import ifsp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  load_t                 load_i,
  input  logic [BASE_W-1:0]     base_i,
  input  logic [STEP_W-1:0]     step_i,
  input  logic [COUNT_BITS-1:0] count_i,
  output logic [CHANNELS-1:0]   match_o
);

  logic [CHANNELS-1:0][COUNT_BITS-1:0] width_q, width_d;

  always_comb begin
    logic [15:0] prod;
    logic [31:0] sum;
    width_d = width_q;
    for (int i = 0; i < CHANNELS; i++) begin
      prod = 16'(load_i.percent[i]) * 16'(step_i);
      sum  = 32'(base_i) + 32'(prod);
      if (load_i.load) begin
        width_d[i] = sum[COUNT_BITS-1:0];
      end
      match_o[i] = (count_i == width_q[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        width_q[i] <= WIDTH_RESET;
      end
    end else begin
      width_q <= width_d;
    end
  end

endmodule

FILE: src/i2c_framed_servo_pulse_generator_unit.sv
// Bus-slave servo pulse generator.
// Input stream: one request per bus event or timer tick. s_axis_tuser is the
// event kind (address+write, address+read, data byte, tick), s_axis_tdata the
// bus byte. Output stream: exactly one result per request, carrying the pin
// levels, reply byte, frame status, radio select and burst flag in tdata;
// tuser is high when the reply byte is meaningful.
// Config port: cfg_we_i writes register cfg_idx_i (0 device address,
// 1 pulse base, 2 pulse step); write only while idle.
// Output: each result is registered before the master side sees it.
// Throughput: one request per cycle unless m_axis_tready stalls; all of the
// work is one short combinational pass (six 8x8 width products, six 16-bit
// compares) between the input handshake and the result register.
// Reset: not addressed, no burst, pins low, radio selected, channel widths at
// reset base plus fifty reset steps.
// Stall: the result register holds while m_axis_tready is low; s_axis_tready
// is high whenever that register is empty or being drained.
module i2c_framed_servo_pulse_generator_unit
  import ifsp_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // config write port
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_W-1:0]       cfg_data_i,
  // request stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [7:0]             s_axis_tdata,   // [7:0] byte_value
  input  logic [1:0]             s_axis_tuser,   // [1:0] req_type
  // result stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [5:0] pin_levels, [13:6] reply_byte, [15:14] frame_status,
  // [16] radio_select, [17] pulsing, rest zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                   m_axis_tuser    // [0] reply_valid
);

  // config registers
  logic [ADDR_W-1:0] dev_addr_q;
  logic [BASE_W-1:0] base_q;
  logic [STEP_W-1:0] step_q;

  // frame and burst state
  logic                          burst_q, burst_d;
  logic                          addressed_q, addressed_d;
  logic [POS_BITS-1:0]           pos_q, pos_d;
  logic [FRAME_LEN-1:0][7:0]     fb_q, fb_d;
  logic [7:0]                    xor_q, xor_d;
  logic [CHANNELS-1:0]           next_q, next_d;
  logic [CHANNELS-1:0]           pend_q, pend_d;
  logic [COUNT_BITS-1:0]         cnt_q, cnt_d;
  logic [CHANNELS-1:0]           pin_q, pin_d;
  logic                          radio_q, radio_d;

  // result register
  logic                          out_valid_q;
  logic [OUT_TDATA_W-1:0]        out_data_q, out_data_d;
  logic                          out_rvalid_q;

  logic     accept;
  req_e     req;
  logic [7:0] byte_in;
  logic     rvalid;
  logic [7:0] rbyte;
  status_e  status;
  load_t    load;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic [CHANNELS-1:0]   match;
  logic [FB_IDX_W-1:0]   wr_idx;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign req           = req_e'(s_axis_tuser);
  assign byte_in       = s_axis_tdata;
  assign wr_idx        = pos_q[FB_IDX_W-1:0];

  ifsp_width_bank u_width_bank (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (load),
    .base_i  (base_q),
    .step_i  (step_q),
    .count_i (cnt_inc),
    .match_o (match)
  );

  // tick count for this tick; restarts from zero at burst end
  always_comb begin
    logic [COUNT_BITS-1:0] start;
    start   = (pend_q == '0) ? '0 : cnt_q;
    cnt_inc = start + COUNT_BITS'(1);
  end

  always_comb begin
    burst_d     = burst_q;
    addressed_d = addressed_q;
    pos_d       = pos_q;
    fb_d        = fb_q;
    xor_d       = xor_q;
    next_d      = next_q;
    pend_d      = pend_q;
    cnt_d       = cnt_q;
    pin_d       = pin_q;
    radio_d     = radio_q;
    rvalid      = 1'b0;
    rbyte       = '0;
    status      = ST_NONE;
    load.load   = 1'b0;
    for (int i = 0; i < CHANNELS; i++) begin
      load.percent[i] = fb_q[i+1];
    end

    if (accept) begin
      if (!burst_q) begin
        case (req)
          REQ_ADDR_WR: begin
            pos_d = '0;
            if (byte_in == {dev_addr_q, 1'b0}) begin
              addressed_d = 1'b1;
            end
          end
          REQ_ADDR_RD: begin
            if (addressed_q) begin
              rvalid = 1'b1;
              if (xor_q == fb_q[FRAME_LEN-1]) begin
                rbyte     = REPLY_ACK;
                status    = ST_ACCEPTED;
                load.load = 1'b1;
              end else begin
                rbyte  = REPLY_NAK;
                status = ST_CSUM_FAIL;
              end
              burst_d     = 1'b1;
              next_d      = '1;
              pend_d      = '1;
              radio_d     = (fb_q[0] & MODE_RADIO_OFF) == '0;
              addressed_d = 1'b0;
              pos_d       = POS_BITS'(POS_DONE);
            end
          end
          REQ_DATA: begin
            if (addressed_q) begin
              if (pos_q == '0) begin
                fb_d[0] = byte_in;
                xor_d   = byte_in;
                pos_d   = POS_BITS'(1);
              end else if (pos_q < POS_BITS'(FRAME_LEN - 1)) begin
                fb_d[wr_idx] = byte_in;
                xor_d        = xor_q ^ byte_in;
                pos_d        = pos_q + POS_BITS'(1);
              end else if (pos_q == POS_BITS'(FRAME_LEN - 1)) begin
                fb_d[FRAME_LEN-1] = byte_in;
                pos_d             = POS_BITS'(POS_DONE);
              end
            end
          end
          default: ;  // ticks outside a burst are dropped
        endcase
      end else if (req == REQ_TICK) begin
        pin_d = next_q;
        if (pend_q == '0) begin
          burst_d = 1'b0;
        end
        cnt_d  = cnt_inc;
        pend_d = pend_q & ~match;
        next_d = next_q & ~match;
      end
    end

    out_data_d = '0;
    out_data_d[CHANNELS-1:0]              = pin_d;
    out_data_d[CHANNELS+7:CHANNELS]       = rbyte;
    out_data_d[CHANNELS+9:CHANNELS+8]     = status;
    out_data_d[CHANNELS+10]               = radio_d;
    out_data_d[CHANNELS+11]               = burst_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q   <= ADDR_RESET;
      base_q       <= BASE_RESET;
      step_q       <= STEP_RESET;
      burst_q      <= 1'b0;
      addressed_q  <= 1'b0;
      pos_q        <= '0;
      fb_q         <= '0;
      xor_q        <= '0;
      next_q       <= '1;
      pend_q       <= '1;
      cnt_q        <= '0;
      pin_q        <= '0;
      radio_q      <= 1'b1;
      out_valid_q  <= 1'b0;
      out_rvalid_q <= 1'b0;
      out_data_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_DEVICE_ADDRESS: dev_addr_q <= cfg_data_i[ADDR_W-1:0];
          CFG_PULSE_BASE:     base_q     <= cfg_data_i[BASE_W-1:0];
          CFG_PULSE_STEP:     step_q     <= cfg_data_i[STEP_W-1:0];
          default: ;
        endcase
      end
      burst_q     <= burst_d;
      addressed_q <= addressed_d;
      pos_q       <= pos_d;
      fb_q        <= fb_d;
      xor_q       <= xor_d;
      next_q      <= next_d;
      pend_q      <= pend_d;
      cnt_q       <= cnt_d;
      pin_q       <= pin_d;
      radio_q     <= radio_d;
      if (accept) begin
        out_valid_q  <= 1'b1;
        out_rvalid_q <= rvalid;
        out_data_q   <= out_data_d;
      end else if (m_axis_tready) begin
        out_valid_q  <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_rvalid_q;

`ifndef SYNTHESIS
  // a reply always starts a burst
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tdata[CHANNELS+11])
    else $error("reply without burst");

  // channels fall together in both masks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_q == pend_q)
    else $error("level and pending masks diverged");

  // bus is never addressed during a burst
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    burst_q |-> !addressed_q)
    else $error("addressed while pulsing");

  // a burst only ends on an accepted tick
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(burst_q) |-> $past(accept && req == REQ_TICK))
    else $error("burst ended without tick");

  // frame position stays in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= POS_BITS'(POS_DONE))
    else $error("frame position out of range");
`endif

endmodule

FILE: tb/tb.sv
module tb;
  import ifsp_pkg::*;

  // ---------------------------------------------------------------------------
  // Bench knobs
  // ---------------------------------------------------------------------------
  localparam int unsigned CYCLE_LIMIT  = 3000000; // timeout, far above a clean run
  localparam int unsigned PHASE_ITEMS  = 200;     // random requests per config phase
  localparam int unsigned RAND_PHASES  = 4;
  localparam int unsigned SETTLE_WAIT  = 4;       // keep margin after the last result

  // One bus event or timer tick as it travels on the request stream
  typedef struct packed {
    req_e       kind;
    logic [7:0] val;
  } bus_req_t;

  // One result as the block should present it
  typedef struct packed {
    logic [CHANNELS-1:0] pins;
    logic                rvalid;
    logic [7:0]          reply;
    status_e             status;
    logic                radio;
    logic                pulsing;
  } servo_out_t;

  // ---------------------------------------------------------------------------
  // DUT hookup
  // ---------------------------------------------------------------------------
  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_idx_i;
  logic [CFG_W-1:0]       cfg_data_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [7:0]             s_axis_tdata;   // [7:0] byte_value
  logic [1:0]             s_axis_tuser;   // [1:0] req_type
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  // [5:0] pin_levels, [13:6] reply_byte, [15:14] frame_status,
  // [16] radio_select, [17] pulsing
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;   // [0] reply_valid

  i2c_framed_servo_pulse_generator_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // ---------------------------------------------------------------------------
  // Bench state
  // ---------------------------------------------------------------------------
  bus_req_t   bus_q[$];         // requests waiting for the driver
  servo_out_t event_result_q[$]; // expected results, oldest first
  int unsigned issued;          // requests queued so far
  int          errors;

  // Predictor copy of the config registers
  logic [ADDR_W-1:0] dev_addr;
  logic [BASE_W-1:0] base_ticks;
  logic [STEP_W-1:0] step_ticks;

  // Predictor copy of the block state
  logic                  burst_on;
  logic                  addr_ok;
  int unsigned           fpos;
  logic [7:0]            fbytes [FRAME_LEN];
  logic [7:0]            rxor;
  logic [COUNT_BITS-1:0] widths [CHANNELS];
  logic [CHANNELS-1:0]   nxt_lv;
  logic [CHANNELS-1:0]   pend_mask;
  logic [COUNT_BITS-1:0] tcnt;
  logic [CHANNELS-1:0]   pins;
  logic                  radio;

  // Driver / receiver pacing
  logic tx_taken;
  int   tx_gap;
  int   tx_steady;
  int   rx_stall;
  int   rx_steady;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic logic [COUNT_BITS-1:0] pulse_len(input logic [7:0] pct);
    logic [31:0] w;
    w = 32'(base_ticks) + 32'(pct) * 32'(step_ticks);
    return w[COUNT_BITS-1:0];
  endfunction

  task automatic servo_reset();
    dev_addr   = ADDR_RESET;
    base_ticks = BASE_RESET;
    step_ticks = STEP_RESET;
    burst_on   = 1'b0;
    addr_ok    = 1'b0;
    fpos       = 0;
    rxor       = '0;
    for (int i = 0; i < FRAME_LEN; i++) fbytes[i] = '0;
    for (int i = 0; i < CHANNELS; i++) widths[i] = pulse_len(8'(MID_PERCENT));
    nxt_lv    = '1;
    pend_mask = '1;
    tcnt      = '0;
    pins      = '0;
    radio     = 1'b1;
  endtask

  task automatic servo_config(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    case (idx)
      CFG_DEVICE_ADDRESS: dev_addr   = val[ADDR_W-1:0];
      CFG_PULSE_BASE:     base_ticks = val[BASE_W-1:0];
      CFG_PULSE_STEP:     step_ticks = val[STEP_W-1:0];
      default: ;
    endcase
  endtask

  // Advance the predictor by one accepted request and queue its result
  task automatic servo_predict(input req_e req, input logic [7:0] b);
    servo_out_t r;
    logic       good;
    r = '0;
    if (!burst_on) begin
      case (req)
        REQ_ADDR_WR: begin
          // restarts the frame even on a mismatch; a mismatch keeps addr_ok
          fpos = 0;
          if (b == {dev_addr, 1'b0}) addr_ok = 1'b1;
        end
        REQ_ADDR_RD: if (addr_ok) begin
          good     = (rxor == fbytes[FRAME_LEN-1]);
          r.rvalid = 1'b1;
          if (good) begin
            r.reply  = REPLY_ACK;
            r.status = ST_ACCEPTED;
            for (int i = 0; i < CHANNELS; i++) widths[i] = pulse_len(fbytes[i+1]);
          end else begin
            r.reply  = REPLY_NAK;
            r.status = ST_CSUM_FAIL;
          end
          burst_on  = 1'b1;
          nxt_lv    = '1;
          pend_mask = '1;
          radio     = ((fbytes[0] & MODE_RADIO_OFF) == 8'h00);
          addr_ok   = 1'b0;
          fpos      = POS_DONE;
        end
        REQ_DATA: if (addr_ok) begin
          if (fpos == 0) begin
            fbytes[0] = b;
            rxor      = b;
            fpos      = 1;
          end else if (fpos < FRAME_LEN - 1) begin
            fbytes[fpos] = b;
            rxor        ^= b;
            fpos++;
          end else if (fpos == FRAME_LEN - 1) begin
            fbytes[FRAME_LEN-1] = b;
            fpos                = POS_DONE;
          end
          // bytes past the checksum fall through untouched
        end
        default: ; // ticks outside a burst
      endcase
    end else if (req == REQ_TICK) begin
      pins = nxt_lv;
      // burst end: levels still copied, then the count restarts on this tick
      if (pend_mask == '0) begin
        burst_on = 1'b0;
        tcnt     = '0;
      end
      tcnt = tcnt + 1'b1;
      for (int i = 0; i < CHANNELS; i++) begin
        if (tcnt == widths[i]) begin
          pend_mask[i] = 1'b0;
          nxt_lv[i]    = 1'b0;
        end
      end
    end
    r.pins    = pins;
    r.radio   = radio;
    r.pulsing = burst_on;
    event_result_q.push_back(r);
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: falling edge, pops bus_q, random gaps between requests
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && !tx_taken) begin
        // hold the current request until it is taken
      end else if (tx_gap != 0) begin
        s_axis_tvalid <= 1'b0;
        tx_gap--;
      end else if (bus_q.size() != 0) begin
        bus_req_t it;
        it = bus_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.kind;
        s_axis_tdata  <= it.val;
        if (tx_steady != 0) begin
          tx_steady--;
          tx_gap = 0;
        end else begin
          tx_gap = pick_gap();
          if ($urandom_range(0, 199) == 0) tx_steady = $urandom_range(20, 80);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver: random stalls on tready, with stall-free stretches
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (rx_stall != 0) begin
        m_axis_tready <= 1'b0;
        rx_stall--;
      end else begin
        m_axis_tready <= 1'b1;
        if (rx_steady != 0) begin
          rx_steady--;
        end else begin
          rx_stall = pick_gap();
          if ($urandom_range(0, 199) == 0) rx_steady = $urandom_range(20, 80);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: rising edge; check results first, then predict the new request
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (event_result_q.size() == 0) begin
          $error("result with no request outstanding: tdata %h", m_axis_tdata);
          errors++;
        end else begin
          servo_out_t want;
          want = event_result_q.pop_front();
          check_field("pin_levels",   want.pins,    m_axis_tdata[5:0]);
          check_field("reply_valid",  want.rvalid,  m_axis_tuser);
          check_field("reply_byte",   want.reply,   m_axis_tdata[13:6]);
          check_field("frame_status", want.status,  m_axis_tdata[15:14]);
          check_field("radio_select", want.radio,   m_axis_tdata[16]);
          check_field("pulsing",      want.pulsing, m_axis_tdata[17]);
        end
      end
      tx_taken = s_axis_tvalid && s_axis_tready;
      if (tx_taken) servo_predict(req_e'(s_axis_tuser), s_axis_tdata);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic send(input req_e kind, input logic [7:0] val);
    bus_req_t it;
    it.kind = kind;
    it.val  = val;
    bus_q.push_back(it);
    issued++;
  endtask

  // Wait until the driver has handed over every queued request
  task automatic drain_requests();
    do @(posedge clk_i); while (bus_q.size() != 0 || s_axis_tvalid);
  endtask

  // Idle point: all requests taken, all results back, pipeline empty
  task automatic settle();
    drain_requests();
    while (event_result_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_WAIT) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    servo_config(idx, val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [7:0] wrong_addr();
    return {dev_addr, 1'b0} ^ 8'($urandom_range(1, 255));
  endfunction

  // Full frame: our address, mode, percents, checksum (optionally spoiled),
  // some trailing junk bytes, then the read address that ends it
  task automatic send_frame(input logic [7:0] mode, input logic [8*CHANNELS-1:0] pcts,
                            input logic [7:0] spoil, input int extra);
    logic [7:0] csum;
    send(REQ_ADDR_WR, {dev_addr, 1'b0});
    send(REQ_DATA, mode);
    csum = mode;
    for (int i = 0; i < CHANNELS; i++) begin
      send(REQ_DATA, pcts[8*i +: 8]);
      csum ^= pcts[8*i +: 8];
    end
    send(REQ_DATA, csum ^ spoil);
    repeat (extra) send(REQ_DATA, 8'($urandom));
    send(REQ_ADDR_RD, {dev_addr, 1'b1});
  endtask

  // Feed ticks until the predicted burst is over; now and then a bus event
  // lands in the burst and must be ignored
  task automatic tick_until_idle(input int chunk);
    drain_requests();
    while (burst_on) begin
      repeat (chunk) begin
        if ($urandom_range(0, 19) == 0) send(req_e'($urandom_range(0, 2)), 8'($urandom));
        send(REQ_TICK, 8'($urandom));
      end
      drain_requests();
    end
  endtask

  task automatic rand_sequence(input int pct_max);
    logic [8*CHANNELS-1:0] pcts;
    logic [7:0]            spoil;
    req_e                  k;
    logic [7:0]            b;
    int                    n;
    if ($urandom_range(0, 99) < 75) begin
      // mostly well-formed frames with random content
      if ($urandom_range(0, 9) == 0) send(REQ_ADDR_WR, wrong_addr());
      if ($urandom_range(0, 9) == 0) send(REQ_TICK, 8'($urandom));
      for (int i = 0; i < CHANNELS; i++) pcts[8*i +: 8] = 8'($urandom_range(0, pct_max));
      spoil = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
      send_frame(8'($urandom), pcts, spoil,
                 ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0);
    end else begin
      // noise: random events, broken and short frames
      n = $urandom_range(1, 10);
      repeat (n) begin
        k = req_e'($urandom_range(0, 3));
        b = 8'($urandom);
        if (k == REQ_ADDR_WR && $urandom_range(0, 2) == 0) b = {dev_addr, 1'b0};
        send(k, b);
      end
    end
    tick_until_idle(8);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned start;
    int          pct_max;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_DEVICE_ADDRESS;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = REQ_TICK;
    m_axis_tready = 1'b0;
    tx_taken      = 1'b0;
    tx_gap        = 0;
    tx_steady     = 0;
    rx_stall      = 0;
    rx_steady     = 0;
    issued        = 0;
    errors        = 0;
    servo_reset();

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // --- directed, reset config: events that never start a burst ---
    send(REQ_TICK, 8'h00);                  // tick outside a burst
    send(REQ_DATA, 8'hAA);                  // not addressed yet
    send(REQ_ADDR_RD, 8'h21);               // not addressed yet
    send(REQ_ADDR_WR, {dev_addr, 1'b1});    // address mismatch
    send(REQ_DATA, 8'h55);
    send(REQ_ADDR_WR, {dev_addr, 1'b0});    // match
    send(REQ_ADDR_WR, wrong_addr());        // mismatch keeps addressed, restarts
    send(REQ_DATA, 8'h11);                  // addressed mode byte

    // --- directed, short widths; reset widths would need over a thousand ticks ---
    settle();
    cfg_write(CFG_PULSE_BASE, CFG_W'(4));
    cfg_write(CFG_PULSE_STEP, CFG_W'(1));
    // good frame, radio off, junk after the checksum
    send_frame(8'h01, 48'h050403020100, 8'h00, 2);
    tick_until_idle(32);
    // bad checksum: widths of the good frame stay in force, radio back on
    send_frame(8'h00, 48'h0F0E0D0C0B0A, 8'h80, 0);
    tick_until_idle(32);

    // --- directed, top of every register; widths wrap to short values ---
    settle();
    cfg_write(CFG_DEVICE_ADDRESS, CFG_W'(127));
    cfg_write(CFG_PULSE_BASE, CFG_W'(65535));
    cfg_write(CFG_PULSE_STEP, CFG_W'(255));
    send_frame(8'hFF, 48'h010101010101, 8'h00, 0);
    tick_until_idle(32);

    // --- directed, bottom of address and base; unit step keeps widths short ---
    settle();
    cfg_write(CFG_DEVICE_ADDRESS, CFG_W'(0));
    cfg_write(CFG_PULSE_BASE, CFG_W'(0));
    cfg_write(CFG_PULSE_STEP, CFG_W'(1));
    send_frame(8'hFE, 48'h070605040302, 8'h00, 0);
    tick_until_idle(8);

    // --- random phases; sender fully pauses at each phase boundary ---
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      settle();
      cfg_write(CFG_DEVICE_ADDRESS, CFG_W'($urandom_range(0, 127)));
      cfg_write(CFG_PULSE_BASE, CFG_W'($urandom_range(2, 12)));
      // last phase: zero step, so full-range percents still give short bursts
      cfg_write(CFG_PULSE_STEP, CFG_W'((ph == RAND_PHASES - 1) ? 0 : $urandom_range(0, 1)));
      pct_max = (ph == RAND_PHASES - 1) ? 255 : 15;
      start   = issued;
      while (issued - start < PHASE_ITEMS) rand_sequence(pct_max);
    end

    drain_requests();
    while (event_result_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_WAIT) @(posedge clk_i);
    if (errors == 0 && event_result_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: sim.f
src/ifsp_pkg.sv
src/ifsp_width_bank.sv
src/i2c_framed_servo_pulse_generator_unit.sv
tb/tb.sv
